// ===== rtl/core/radar_target_frame_decoder_top_assert.svh =====
// Assertion macros for the radar target frame decoder
`ifndef RADAR_TARGET_FRAME_DECODER_TOP_ASSERT_SVH
`define RADAR_TARGET_FRAME_DECODER_TOP_ASSERT_SVH
`ifndef SYNTH
`define RTFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RTFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RTFD_ASSERT(lbl, prop, msg)
`define RTFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/rtfd_pkg.sv =====
// Shared types, constants and word decoding for the radar target frame decoder
package rtfd_pkg;

  localparam int unsigned WindowLen = 30;
  localparam int unsigned HeadLen   = 4;
  localparam int unsigned SlotLen   = 8;
  localparam int unsigned FillW     = 5;

  localparam logic [7:0] Head0 = 8'hAA;
  localparam logic [7:0] Head1 = 8'hFF;
  localparam logic [7:0] Head2 = 8'h03;
  localparam logic [7:0] Head3 = 8'h00;
  localparam logic [7:0] Foot0 = 8'h55;
  localparam logic [7:0] Foot1 = 8'hCC;

  localparam logic [14:0] MinValidYReset = 15'd320;

  typedef logic [SlotLen-1:0][7:0] slot_bytes_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] speed;
    logic [15:0]        dist_res;
    logic               valid;
  } target_t;

  // Offset-sign word: top bit set means positive magnitude, clear means negative.
  function automatic logic signed [15:0] decode_word(input logic [15:0] raw);
    logic [15:0] mag;
    mag = {1'b0, raw[14:0]};
    if (raw[15]) begin
      return $signed(mag);
    end
    return $signed(16'd0 - mag);
  endfunction

endpackage

// ===== rtl/core/rtfd_slot_decode.sv =====
// Decoder for the eight bytes of one target slot
module rtfd_slot_decode (
  input  rtfd_pkg::slot_bytes_t slot_bytes_i,
  input  logic [14:0]           min_valid_y_i,
  output rtfd_pkg::target_t     target_o
);

  logic [15:0]        raw_x;
  logic [15:0]        raw_y;
  logic [15:0]        raw_s;
  logic [15:0]        raw_d;
  logic signed [15:0] dec_y;

  // Little-endian words
  assign raw_x = {slot_bytes_i[1], slot_bytes_i[0]};
  assign raw_y = {slot_bytes_i[3], slot_bytes_i[2]};
  assign raw_s = {slot_bytes_i[5], slot_bytes_i[4]};
  assign raw_d = {slot_bytes_i[7], slot_bytes_i[6]};

  assign dec_y = rtfd_pkg::decode_word(raw_y);

  always_comb begin
    target_o.pos_x    = rtfd_pkg::decode_word(raw_x);
    target_o.pos_y    = dec_y;
    target_o.speed    = rtfd_pkg::decode_word(raw_s);
    target_o.dist_res = raw_d;
    target_o.valid    = ((raw_x | raw_y | raw_s) != 16'd0) &&
                        (dec_y >= $signed({1'b0, min_valid_y_i}));
  end

endmodule

// ===== rtl/core/radar_target_frame_decoder_top.sv =====
// Radar report frame decoder: sliding byte window, frame match and target output
//
//   channel   direction  handshake                   payload
//   input     in         in_valid_i / in_stall_o     data_byte_i
//   result    out        out_valid_o / out_stall_i   target_slot_o .. last_target_o
//   config    in         cfg_we_i                    cfg_wdata_i (min_valid_y)
//
// One byte is taken every unstalled cycle; the window is a 30-stage shift line.
// A completed frame is decoded in the cycle of its last byte and its targets
// leave one per unstalled cycle from a slot buffer, TARGET_SLOTS per frame.
// Input stalls only when the buffer is still draining and the next byte could
// complete another frame. Reset empties the window and sets min_valid_y to 320.
module radar_target_frame_decoder_top #(
  parameter int unsigned TARGET_SLOTS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         target_slot_o,
  output logic signed [15:0] pos_x_mm_o,
  output logic signed [15:0] pos_y_mm_o,
  output logic signed [15:0] speed_cm_s_o,
  output logic [15:0]        dist_resolution_o,
  output logic               target_valid_o,
  output logic               last_target_o
);

  localparam int unsigned SlotW = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TARGET_SLOTS - 1);
  localparam logic [rtfd_pkg::FillW-1:0] FullMinusOne =
    rtfd_pkg::FillW'(rtfd_pkg::WindowLen - 1);

  logic [7:0]                 win_q [rtfd_pkg::WindowLen];
  logic [7:0]                 nwin  [rtfd_pkg::WindowLen];
  logic [rtfd_pkg::FillW-1:0] fill_q, fill_d;
  logic [14:0]                min_y_q;
  logic                       pend_q, pend_d;
  logic [SlotW-1:0]           slot_q, slot_d;
  rtfd_pkg::target_t          buf_q [TARGET_SLOTS];
  rtfd_pkg::target_t          dec   [TARGET_SLOTS];
  rtfd_pkg::target_t          cur;
  logic                       in_xfer, out_xfer, frame_ok, frame_hit;

  assign in_stall_o = pend_q && (fill_q == FullMinusOne);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;

  // Window as it stands once this byte is in
  always_comb begin
    for (int unsigned i = 0; i < rtfd_pkg::WindowLen - 1; i++) begin
      nwin[i] = win_q[i+1];
    end
    nwin[rtfd_pkg::WindowLen-1] = data_byte_i;
  end

  assign frame_ok = (nwin[0] == rtfd_pkg::Head0) && (nwin[1] == rtfd_pkg::Head1) &&
                    (nwin[2] == rtfd_pkg::Head2) && (nwin[3] == rtfd_pkg::Head3) &&
                    (nwin[rtfd_pkg::WindowLen-2] == rtfd_pkg::Foot0) &&
                    (nwin[rtfd_pkg::WindowLen-1] == rtfd_pkg::Foot1);
  assign frame_hit = in_xfer && (fill_q == FullMinusOne) && frame_ok;

  for (genvar s = 0; s < TARGET_SLOTS; s++) begin : g_slot
    rtfd_pkg::slot_bytes_t sb;
    for (genvar j = 0; j < rtfd_pkg::SlotLen; j++) begin : g_byte
      assign sb[j] = nwin[rtfd_pkg::HeadLen + s * rtfd_pkg::SlotLen + j];
    end
    rtfd_slot_decode u_dec (
      .slot_bytes_i (sb),
      .min_valid_y_i(min_y_q),
      .target_o     (dec[s])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (in_xfer) begin
      if (fill_q != FullMinusOne) begin
        fill_d = fill_q + 1'b1;
      end else if (frame_ok) begin
        fill_d = '0;
      end
      // full without a frame: oldest byte drops, count stays at 29
    end
  end

  always_comb begin
    pend_d = pend_q;
    slot_d = slot_q;
    if (frame_hit) begin
      pend_d = 1'b1;
      slot_d = '0;
    end else if (out_xfer) begin
      if (slot_q == LastSlot) begin
        pend_d = 1'b0;
      end else begin
        slot_d = slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      pend_q  <= 1'b0;
      slot_q  <= '0;
      min_y_q <= rtfd_pkg::MinValidYReset;
    end else begin
      fill_q <= fill_d;
      pend_q <= pend_d;
      slot_q <= slot_d;
      if (cfg_we_i) begin
        min_y_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      win_q <= nwin;
    end
    if (frame_hit) begin
      buf_q <= dec;
    end
  end

  assign cur = buf_q[slot_q];

  assign out_valid_o       = pend_q;
  assign target_slot_o     = 2'(slot_q);
  assign pos_x_mm_o        = cur.pos_x;
  assign pos_y_mm_o        = cur.pos_y;
  assign speed_cm_s_o      = cur.speed;
  assign dist_resolution_o = cur.dist_res;
  assign target_valid_o    = cur.valid;
  assign last_target_o     = (slot_q == LastSlot);

`include "radar_target_frame_decoder_top_assert.svh"

  `RTFD_ASSERT(a_fill_range, fill_q <= FullMinusOne, "fill count beyond window")
  `RTFD_ASSERT(a_no_overwrite, frame_hit |-> !pend_q, "frame captured over pending targets")
  `RTFD_ASSERT(a_drain_ends, out_xfer && last_target_o |=> !out_valid_o, "results after last target")
  `RTFD_ASSERT(a_first_slot, $rose(out_valid_o) |-> target_slot_o == 2'd0, "frame not starting at slot 0")
  `RTFD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the radar target frame decoder top level
module testbench;

  localparam int unsigned Slots       = 3;
  localparam int unsigned FrameWords  =
    (rtfd_pkg::WindowLen - rtfd_pkg::HeadLen - 2) / 2;
  localparam int unsigned DrainCycles = Slots + 8;
  localparam int unsigned StallLimit  = 2000;

  typedef struct packed {
    logic [1:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] speed;
    logic [15:0]        dist_res;
    logic               valid;
    logic               last;
  } target_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [14:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        out_stall_i = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [1:0]         target_slot_o;
  logic signed [15:0] pos_x_mm_o;
  logic signed [15:0] pos_y_mm_o;
  logic signed [15:0] speed_cm_s_o;
  logic [15:0]        dist_resolution_o;
  logic               target_valid_o;
  logic               last_target_o;

  radar_target_frame_decoder_top #(
    .TARGET_SLOTS(Slots)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .target_slot_o    (target_slot_o),
    .pos_x_mm_o       (pos_x_mm_o),
    .pos_y_mm_o       (pos_y_mm_o),
    .speed_cm_s_o     (speed_cm_s_o),
    .dist_resolution_o(dist_resolution_o),
    .target_valid_o   (target_valid_o),
    .last_target_o    (last_target_o)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: byte window, fill level and Y threshold
  logic [7:0]  win_bytes [rtfd_pkg::WindowLen];
  int unsigned win_fill = 0;
  logic [14:0] min_y = rtfd_pkg::MinValidYReset;

  logic [7:0]     stream_bytes [$];
  target_result_t pending_targets [$];

  int unsigned send_idle = 14;
  int unsigned recv_idle = 71;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  logic        in_taken = 1'b0;

  function automatic logic signed [15:0] offset_sign_mm(input logic [15:0] raw);
    logic signed [15:0] mag;
    mag = $signed({1'b0, raw[14:0]});
    return raw[15] ? mag : -mag;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    int unsigned base;
    int unsigned i;
    logic [15:0] rx, ry, rs, rd;
    target_result_t t;
    if (win_fill < rtfd_pkg::WindowLen) begin
      win_bytes[win_fill] = b;
      win_fill++;
    end
    if (win_fill == rtfd_pkg::WindowLen) begin
      if (win_bytes[0] == rtfd_pkg::Head0 && win_bytes[1] == rtfd_pkg::Head1 &&
          win_bytes[2] == rtfd_pkg::Head2 && win_bytes[3] == rtfd_pkg::Head3 &&
          win_bytes[rtfd_pkg::WindowLen-2] == rtfd_pkg::Foot0 &&
          win_bytes[rtfd_pkg::WindowLen-1] == rtfd_pkg::Foot1) begin
        for (i = 0; i < Slots; i++) begin
          base = rtfd_pkg::HeadLen + i * rtfd_pkg::SlotLen;
          rx = {win_bytes[base+1], win_bytes[base]};
          ry = {win_bytes[base+3], win_bytes[base+2]};
          rs = {win_bytes[base+5], win_bytes[base+4]};
          rd = {win_bytes[base+7], win_bytes[base+6]};
          t.slot     = 2'(i);
          t.pos_x    = offset_sign_mm(rx);
          t.pos_y    = offset_sign_mm(ry);
          t.speed    = offset_sign_mm(rs);
          t.dist_res = rd;
          t.valid    = ((rx | ry | rs) != 16'd0) && (t.pos_y >= $signed({1'b0, min_y}));
          t.last     = (i == Slots - 1);
          pending_targets.push_back(t);
        end
        win_fill = 0;
      end else begin
        // drop the oldest byte
        for (i = 0; i < rtfd_pkg::WindowLen - 1; i++) win_bytes[i] = win_bytes[i+1];
        win_fill = rtfd_pkg::WindowLen - 1;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Driver: present bytes at the falling edge, hold a stalled transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_valid_i  <= 1'b1;
          data_byte_i <= stream_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // Monitor: predict on each input transfer, check each result transfer
  always @(posedge clk_i) begin
    target_result_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) decode_byte(data_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_targets.size() == 0) begin
          report_mismatch("result with no expectation waiting");
        end else begin
          want = pending_targets.pop_front();
          check_field("target_slot", 16'(target_slot_o), 16'(want.slot));
          check_field("pos_x_mm", pos_x_mm_o, want.pos_x);
          check_field("pos_y_mm", pos_y_mm_o, want.pos_y);
          check_field("speed_cm_s", speed_cm_s_o, want.speed);
          check_field("dist_resolution", dist_resolution_o, want.dist_res);
          check_field("target_valid", 16'(target_valid_o), 16'(want.valid));
          check_field("last_target", 16'(last_target_o), 16'(want.last));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'hFFFF;
      4: return {1'b1, min_y};
      5: return {1'b1, min_y - 15'd1};
      6: return 16'h0001;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Queue one 30-byte frame; corrupt the byte at bad_pos when bad_pos is not negative
  task automatic push_frame(input logic [15:0] words [FrameWords], input int bad_pos);
    logic [7:0] f [rtfd_pkg::WindowLen];
    int i;
    f[0] = rtfd_pkg::Head0;
    f[1] = rtfd_pkg::Head1;
    f[2] = rtfd_pkg::Head2;
    f[3] = rtfd_pkg::Head3;
    f[rtfd_pkg::WindowLen-2] = rtfd_pkg::Foot0;
    f[rtfd_pkg::WindowLen-1] = rtfd_pkg::Foot1;
    for (i = 0; i < FrameWords; i++) begin
      f[rtfd_pkg::HeadLen + 2*i]     = words[i][7:0];
      f[rtfd_pkg::HeadLen + 2*i + 1] = words[i][15:8];
    end
    if (bad_pos >= 0) f[bad_pos] ^= 8'($urandom_range(1, 255));
    foreach (f[i]) stream_bytes.push_back(f[i]);
  endtask

  task automatic random_frame(input bit corrupt);
    logic [15:0] words [FrameWords];
    int idx;
    foreach (words[i]) words[i] = (i % 4 == 3) ? 16'($urandom_range(65535)) : pick_raw();
    idx = $urandom_range(5);
    push_frame(words,
               corrupt ? ((idx < 4) ? idx : rtfd_pkg::WindowLen - 6 + idx) : -1);
  endtask

  task automatic wait_drained();
    while (stream_bytes.size() != 0 || in_valid_i || pending_targets.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_min_y(input logic [14:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    min_y = v;
  endtask

  task automatic run_phase(input int n_items, input bit pause_mid);
    int count;
    int len;
    int r;
    bit paused;
    count  = 0;
    paused = 0;
    while (count < n_items) begin
      // hold off the sender once until every target has been seen
      if (pause_mid && !paused && count >= n_items / 2) begin
        wait_drained();
        paused = 1;
      end
      r = $urandom_range(99);
      if (r < 65) begin
        random_frame(1'b0);
        count += rtfd_pkg::WindowLen;
      end else if (r < 75) begin
        random_frame(1'b1);
        count += rtfd_pkg::WindowLen;
      end else if (r < 88) begin
        len = $urandom_range(1, 12);
        repeat (len) stream_bytes.push_back(8'($urandom_range(255)));
        count += len;
      end else begin
        // short fragment ending in a footer
        len = $urandom_range(0, 6);
        repeat (len) stream_bytes.push_back(8'($urandom_range(255)));
        stream_bytes.push_back(rtfd_pkg::Foot0);
        stream_bytes.push_back(rtfd_pkg::Foot1);
        count += len + 2;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero target, positive and negative extremes, Y on and just below threshold
    push_frame('{16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'hFFFF, {1'b1, rtfd_pkg::MinValidYReset}, 16'h7FFF, 16'hFFFF,
                 16'h8000, {1'b1, rtfd_pkg::MinValidYReset - 15'd1}, 16'h0001,
                 16'h1234}, -1);
    // footer before the window fills, then a frame that slides into place
    stream_bytes.push_back(rtfd_pkg::Head0);
    stream_bytes.push_back(rtfd_pkg::Foot0);
    stream_bytes.push_back(rtfd_pkg::Foot1);
    push_frame('{16'h8000, 16'h8000, 16'h8000, 16'h0000,
                 16'h5A5A, 16'h7FFF, 16'hC3C3, 16'h00FF,
                 16'h0001, 16'hFFFF, 16'h8001, 16'hFF00}, -1);
    wait_drained();

    set_min_y(15'd0);
    run_phase(120, 1'b0);
    wait_drained();

    send_idle = 71;
    recv_idle = 14;
    set_min_y(15'h7FFF);
    run_phase(120, 1'b1);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    set_min_y(15'($urandom_range(32767)));
    run_phase(120, 1'b0);
    wait_drained();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rtfd_pkg.sv
rtl/core/rtfd_slot_decode.sv
rtl/core/radar_target_frame_decoder_top.sv
test/testbench.sv
